// ===== rtl/sarp_pkg.sv =====
// shared types and constants for the servo angle ramp with pwm duty output
`default_nettype none

package sarp_pkg;

  // divider datapath widths
  localparam int unsigned DIV_W  = 36;   // dividend and quotient
  localparam int unsigned DVR_W  = 20;   // divisor and remainder
  localparam int unsigned STEP_W = 6;    // iteration count, up to DIV_W

  // field widths
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned DBITS_W = 5;
  localparam int unsigned DUTY_W  = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // fixed numbers of the duty rule
  localparam logic [ANGLE_W-1:0] ANGLE_FULL    = 8'd180;
  localparam logic [DVR_W-1:0]   US_PER_SEC    = 20'd1000000;
  localparam logic [DBITS_W-1:0] DUTY_BITS_CAP = 5'd20;

  // x / 180 as ((x >> 2) * ceil(2^29 / 45)) >> 29, exact for x below 2^24
  localparam int unsigned        SCALED_W    = 24;   // span times clamped angle
  localparam int unsigned        RECIP_W     = 24;
  localparam int unsigned        RECIP_SHIFT = 29;
  localparam logic [RECIP_W-1:0] RECIP_45    = 24'd11930465;

  // reset values
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd500;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd2500;
  localparam logic [DBITS_W-1:0] DUTY_BITS_RST = 5'd13;
  localparam logic [PULSE_W-1:0] PWM_FREQ_RST  = 16'd50;
  localparam logic [ANGLE_W-1:0] ACT_STEP_RST  = 8'd1;
  localparam logic [DELAY_W-1:0] ACT_DELAY_RST = 16'd100;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_BITS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_FREQ  = 2'd3;

  // input command codes
  localparam logic CMD_TARGET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // result status codes
  localparam logic ST_MOVING  = 1'b0;
  localparam logic ST_REACHED = 1'b1;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;   // left aligned with low bits zero for the period request
    logic [DVR_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/sarp_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module sarp_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sarp_pkg::div_req_t req_i,
  output sarp_pkg::div_rsp_t      rsp_o
);
  import sarp_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DVR_W-1:0]  rem_q, rem_d;
  logic [DVR_W-1:0]  dvr_q, dvr_d;
  logic [DVR_W:0]    trial;
  logic [DVR_W:0]    diff;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvr_d  = dvr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvr_d  = req_i.divisor;
    end else if (busy_q) begin
      // trial subtract, keep the shifted remainder when it goes negative
      if (trial >= {1'b0, dvr_q}) begin
        rem_d = diff[DVR_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DVR_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvr_q <= dvr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/servo_angle_ramp_pwm.sv =====
// servo angle ramp with slew limited steps and pwm duty computation
`default_nettype none

// channel | direction | handshake             | payload
// in      | into      | in_valid_i/in_stall_o | command, target, tolerance, step, delay
// out     | out of    | out_valid_o/out_stall_i | status, angle, target, duty
// cfg     | into      | cfg_valid_i/cfg_ready_o | register index, write data
//
// an item that gives no result leaves the block idle; an item that gives a result
// holds the input through the span product, the reciprocal scaling for the pulse
// width, a divider start and run for the pwm period, the top product and a
// divider start and run for the duty, each divider run closed by its done pulse
// the next item is taken in the cycle the pending result transfers
// asynchronous active low reset, no clearing pass; the cfg port is always ready

module servo_angle_ramp_pwm (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // item input
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic                           in_command_i,
  input  wire logic [sarp_pkg::ANGLE_W-1:0]   in_target_angle_i,
  input  wire logic [sarp_pkg::ANGLE_W-1:0]   in_tolerance_deg_i,
  input  wire logic [sarp_pkg::ANGLE_W-1:0]   in_step_deg_i,
  input  wire logic [sarp_pkg::DELAY_W-1:0]   in_step_delay_ms_i,
  // result output
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic                           out_status_o,
  output      logic [sarp_pkg::ANGLE_W-1:0]   out_angle_o,
  output      logic [sarp_pkg::ANGLE_W-1:0]   out_target_o,
  output      logic [sarp_pkg::DUTY_W-1:0]    out_duty_o,
  // register writes
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [sarp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [sarp_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import sarp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_SPAN,
    S_US_SCALE,
    S_PER_GO,
    S_PER_WAIT,
    S_MUL_TOP,
    S_DUTY_GO,
    S_DUTY_WAIT
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [PULSE_W-1:0] min_pulse_q, max_pulse_q, pwm_freq_q;
  logic [DBITS_W-1:0] duty_bits_q;

  // ramp state
  logic [ANGLE_W-1:0] cur_angle_q, cur_angle_d;
  logic [ANGLE_W-1:0] act_tgt_q, act_tgt_d, act_tol_q, act_tol_d, act_step_q, act_step_d;
  logic [DELAY_W-1:0] act_delay_q, act_delay_d;
  logic               moving_q, moving_d;
  logic [DELAY_W-1:0] wait_left_q, wait_left_d;
  logic               pend_valid_q, pend_valid_d;
  logic [ANGLE_W-1:0] pend_tgt_q, pend_tgt_d, pend_tol_q, pend_tol_d, pend_step_q, pend_step_d;
  logic [DELAY_W-1:0] pend_delay_q, pend_delay_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic               out_status_q, out_status_d;
  logic [ANGLE_W-1:0] out_angle_q, out_angle_d, out_target_q, out_target_d;
  logic [DUTY_W-1:0]  out_duty_q, out_duty_d;

  // duty datapath
  logic [DIV_W-1:0]   prod_q, prod_d;
  logic [PULSE_W-1:0] us_q, us_d;
  logic [DVR_W-1:0]   period_q, period_d;

  logic               in_xfer;
  logic               eval_en;
  logic [ANGLE_W-1:0] sel_tgt, sel_tol, sel_step;
  logic [DELAY_W-1:0] sel_delay;
  logic [DELAY_W-1:0] wait_dec;
  logic [ANGLE_W-1:0] mag;
  logic [ANGLE_W:0]   up_sum;

  logic [ANGLE_W-1:0] ang_clamp;
  logic [PULSE_W-1:0] span;
  logic [DUTY_W-1:0]  top;
  logic [DBITS_W-1:0] bits_eff;
  logic [PULSE_W-1:0] freq_eff;
  logic [PULSE_W:0]   us_sum;
  logic [PULSE_W-1:0] mul_a;
  logic [DUTY_W-1:0]  mul_b;
  logic [DIV_W-1:0]   mul_p;
  logic [SCALED_W-2+RECIP_W-1:0] recip_p;

  div_req_t div_req;
  div_rsp_t div_rsp;

  sarp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next item is taken when idle and once any pending result is on its way out
  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // item handling: pending slot, wait countdown and the step decision
  // ---------------------------------------------------------------------------
  assign wait_dec = wait_left_q - DELAY_W'(1);

  always_comb begin
    cur_angle_d  = cur_angle_q;
    act_tgt_d    = act_tgt_q;
    act_tol_d    = act_tol_q;
    act_step_d   = act_step_q;
    act_delay_d  = act_delay_q;
    moving_d     = moving_q;
    wait_left_d  = wait_left_q;
    pend_valid_d = pend_valid_q;
    pend_tgt_d   = pend_tgt_q;
    pend_tol_d   = pend_tol_q;
    pend_step_d  = pend_step_q;
    pend_delay_d = pend_delay_q;
    out_status_d = out_status_q;
    out_angle_d  = out_angle_q;
    out_target_d = out_target_q;
    eval_en      = 1'b0;
    sel_tgt      = act_tgt_q;
    sel_tol      = act_tol_q;
    sel_step     = act_step_q;
    sel_delay    = act_delay_q;

    if (in_xfer) begin
      if (in_command_i == CMD_TARGET) begin
        if (wait_left_q != '0) begin
          // wait running: park the command, a newer one overwrites it
          pend_valid_d = 1'b1;
          pend_tgt_d   = in_target_angle_i;
          pend_tol_d   = in_tolerance_deg_i;
          pend_step_d  = in_step_deg_i;
          pend_delay_d = in_step_delay_ms_i;
        end else begin
          sel_tgt   = in_target_angle_i;
          sel_tol   = in_tolerance_deg_i;
          sel_step  = in_step_deg_i;
          sel_delay = in_step_delay_ms_i;
          moving_d  = 1'b1;
          eval_en   = 1'b1;
        end
      end else if (wait_left_q != '0) begin
        // tick with a wait running; a tick with none is dropped
        wait_left_d = wait_dec;
        if (wait_dec == '0) begin
          if (pend_valid_q) begin
            sel_tgt      = pend_tgt_q;
            sel_tol      = pend_tol_q;
            sel_step     = pend_step_q;
            sel_delay    = pend_delay_q;
            pend_valid_d = 1'b0;
            moving_d     = 1'b1;
            eval_en      = 1'b1;
          end else begin
            eval_en = moving_q;
          end
        end
      end
    end

    mag    = (sel_tgt >= cur_angle_q) ? (sel_tgt - cur_angle_q) : (cur_angle_q - sel_tgt);
    up_sum = {1'b0, cur_angle_q} + {1'b0, sel_step};

    if (eval_en) begin
      act_tgt_d   = sel_tgt;
      act_tol_d   = sel_tol;
      act_step_d  = sel_step;
      act_delay_d = sel_delay;
      if (mag > sel_tol) begin
        if (sel_tgt > cur_angle_q) begin
          // upward, clamped at the target
          cur_angle_d = (up_sum > {1'b0, sel_tgt}) ? sel_tgt : up_sum[ANGLE_W-1:0];
        end else begin
          // downward, floor at zero
          cur_angle_d = (cur_angle_q > sel_step) ? (cur_angle_q - sel_step) : '0;
        end
        wait_left_d  = (sel_delay == '0) ? DELAY_W'(1) : sel_delay;
        out_status_d = ST_MOVING;
      end else begin
        moving_d     = 1'b0;
        out_status_d = ST_REACHED;
      end
      out_angle_d  = cur_angle_d;
      out_target_d = sel_tgt;
    end
  end

  // ---------------------------------------------------------------------------
  // duty: us = min + span * a / 180, period = 1e6 / freq, duty = us * top / period
  // ---------------------------------------------------------------------------
  assign ang_clamp = (cur_angle_q > ANGLE_FULL) ? ANGLE_FULL : cur_angle_q;
  assign span      = (max_pulse_q >= min_pulse_q) ? (max_pulse_q - min_pulse_q) : '0;
  assign bits_eff  = (duty_bits_q > DUTY_BITS_CAP) ? DUTY_BITS_CAP : duty_bits_q;
  assign freq_eff  = (pwm_freq_q == '0) ? PULSE_W'(1) : pwm_freq_q;

  // divide by 180: drop two bits, then multiply by the reciprocal of 45
  assign recip_p = prod_q[SCALED_W-1:2] * RECIP_45;
  assign us_sum  = {1'b0, min_pulse_q} + {1'b0, recip_p[RECIP_SHIFT +: PULSE_W]};

  always_comb begin
    for (int k = 0; k < DUTY_W; k++) begin
      top[k] = (DBITS_W'(k) < bits_eff);
    end
  end

  // multiplier shared by the span and top products; the reciprocal scaling has its own
  assign mul_a = (state_q == S_MUL_TOP) ? us_q : span;
  assign mul_b = (state_q == S_MUL_TOP) ? top : {{(DUTY_W-ANGLE_W){1'b0}}, ang_clamp};
  assign mul_p = mul_a * mul_b;

  always_comb begin
    div_req = '0;
    case (state_q)
      S_PER_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {US_PER_SEC, {(DIV_W-DVR_W){1'b0}}};
        div_req.divisor  = {{(DVR_W-PULSE_W){1'b0}}, freq_eff};
        div_req.steps    = STEP_W'(DVR_W);
      end
      S_DUTY_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = period_q;
        div_req.steps    = STEP_W'(DIV_W);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    prod_d      = prod_q;
    us_d        = us_q;
    period_d    = period_q;
    out_duty_d  = out_duty_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (eval_en) begin
          state_d = S_MUL_SPAN;
        end
      end
      S_MUL_SPAN: begin
        prod_d  = mul_p;
        state_d = S_US_SCALE;
      end
      S_US_SCALE: begin
        us_d    = us_sum[PULSE_W-1:0];
        state_d = S_PER_GO;
      end
      S_PER_GO: begin
        state_d = S_PER_WAIT;
      end
      S_PER_WAIT: begin
        if (div_rsp.done) begin
          period_d = div_rsp.quotient[DVR_W-1:0];
          state_d  = S_MUL_TOP;
        end
      end
      S_MUL_TOP: begin
        prod_d  = mul_p;
        state_d = S_DUTY_GO;
      end
      S_DUTY_GO: begin
        state_d = S_DUTY_WAIT;
      end
      S_DUTY_WAIT: begin
        if (div_rsp.done) begin
          // saturate to the duty field
          out_duty_d  = (div_rsp.quotient[DIV_W-1:DUTY_W] != '0) ? {DUTY_W{1'b1}}
                                                                  : div_rsp.quotient[DUTY_W-1:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      min_pulse_q  <= MIN_PULSE_RST;
      max_pulse_q  <= MAX_PULSE_RST;
      duty_bits_q  <= DUTY_BITS_RST;
      pwm_freq_q   <= PWM_FREQ_RST;
      cur_angle_q  <= '0;
      act_tgt_q    <= '0;
      act_tol_q    <= '0;
      act_step_q   <= ACT_STEP_RST;
      act_delay_q  <= ACT_DELAY_RST;
      moving_q     <= 1'b0;
      wait_left_q  <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_angle_q  <= cur_angle_d;
      act_tgt_q    <= act_tgt_d;
      act_tol_q    <= act_tol_d;
      act_step_q   <= act_step_d;
      act_delay_q  <= act_delay_d;
      moving_q     <= moving_d;
      wait_left_q  <= wait_left_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MIN_PULSE: min_pulse_q <= cfg_data_i;
          CFG_MAX_PULSE: max_pulse_q <= cfg_data_i;
          CFG_DUTY_BITS: duty_bits_q <= cfg_data_i[DBITS_W-1:0];
          CFG_PWM_FREQ:  pwm_freq_q  <= cfg_data_i;
          default:       ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    pend_tgt_q   <= pend_tgt_d;
    pend_tol_q   <= pend_tol_d;
    pend_step_q  <= pend_step_d;
    pend_delay_q <= pend_delay_d;
    out_status_q <= out_status_d;
    out_angle_q  <= out_angle_d;
    out_target_q <= out_target_d;
    out_duty_q   <= out_duty_d;
    prod_q       <= prod_d;
    us_q         <= us_d;
    period_q     <= period_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_angle_o  = out_angle_q;
  assign out_target_o = out_target_q;
  assign out_duty_o   = out_duty_q;

  // a parked command only exists while a wait is counting
  a_pend_needs_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (wait_left_q != '0))
    else $error("pending command held with no wait running");

  // divider completions only land in a waiting state
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_PER_WAIT || state_q == S_DUTY_WAIT))
    else $error("divider finished outside a wait state");

  // a result appears only at the end of the duty division
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DUTY_WAIT))
    else $error("result raised without a duty computation");

  // a moving result always leaves a step wait running
  a_moving_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_MOVING) |-> (wait_left_q != '0))
    else $error("moving status with no step wait");

endmodule

`default_nettype wire
